// File: rtl/bounded_array_list_engine_core_defines.svh
// Assertion macros used by the bounded array list engine top level.
`ifndef BOUNDED_ARRAY_LIST_ENGINE_CORE_DEFINES_SVH
`define BOUNDED_ARRAY_LIST_ENGINE_CORE_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define BALE_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define BALE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/bale_pkg.sv
// Package with sizes, codes and shared types of the bounded array list engine.
package bale_pkg;

  localparam int CAPACITY   = 16;
  localparam int ITEM_WIDTH = 32;
  localparam int CNT_W      = $clog2(CAPACITY + 1);
  localparam int IDX_W      = $clog2(CAPACITY);
  localparam int POS_W      = 4;
  localparam int CMP_W      = (CNT_W > POS_W) ? CNT_W : POS_W;

  typedef logic [ITEM_WIDTH-1:0] item_t;
  typedef logic [CNT_W-1:0]      cnt_t;
  typedef logic [IDX_W-1:0]      idx_t;

  localparam cnt_t CAP_CNT = CNT_W'(CAPACITY);

  typedef enum logic [2:0] {
    ACT_APPEND    = 3'd0,
    ACT_PREPEND   = 3'd1,
    ACT_REMOVE    = 3'd2,
    ACT_REMOVE_AT = 3'd3,
    ACT_CLEAR     = 3'd4,
    ACT_READ_AT   = 3'd5,
    ACT_INCLUDES  = 3'd6,
    ACT_POP       = 3'd7
  } action_e;

  typedef enum logic [1:0] {
    STS_OK    = 2'd0,
    STS_FULL  = 2'd1,
    STS_RANGE = 2'd2
  } status_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic    load;
    logic    exec;
    logic    wr_tail;
    logic    wr_head;
    logic    drop;
    logic    drop_val;
    logic    pop;
    logic    clear;
    logic    rd_en;
    logic    rd_pop;
    logic    found;
    status_e st;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    action_e act;
    logic    full;
    logic    empty;
    logic    pos_ok;
    logic    hit;
  } stat_t;

  // Keep the low item bits of a 32-bit request value.
  function automatic item_t to_item(input logic [31:0] v);
    logic [63:0] w;
    w = {32'd0, v};
    return w[ITEM_WIDTH-1:0];
  endfunction

  // Fit a stored item into the 32-bit read value.
  function automatic logic [31:0] from_item(input item_t v);
    logic [63:0] w;
    w = 64'(v);
    return w[31:0];
  endfunction

  // Fit the count into the 5-bit result field.
  function automatic logic [4:0] from_cnt(input cnt_t c);
    logic [63:0] w;
    w = 64'(c);
    return w[4:0];
  endfunction

endpackage

// File: rtl/bale_ctrl.sv
// Controller state machine of the bounded array list engine.
module bale_ctrl
  import bale_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  s_tvalid_i,
  output logic  s_tready_o,
  output logic  m_tvalid_o,
  input  logic  m_tready_i,
  input  stat_t stat_i,
  output cmd_t  cmd_o
);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } state_e;

  state_e state_q, state_d;
  logic   m_valid_q, m_valid_d;
  logic   slot_free;

  assign s_tready_o = (state_q == S_IDLE);
  assign m_tvalid_o = m_valid_q;
  assign slot_free  = !m_valid_q || m_tready_i;

  // Next state and command decode.
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    cmd_o.st = STS_OK;
    cmd_o.load = s_tvalid_i && s_tready_o;
    unique case (state_q)
      S_IDLE: begin
        if (cmd_o.load) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        if (slot_free) begin
          state_d    = S_IDLE;
          cmd_o.exec = 1'b1;
          unique case (stat_i.act)
            ACT_APPEND: begin
              if (stat_i.full) cmd_o.st = STS_FULL;
              else cmd_o.wr_tail = 1'b1;
            end
            ACT_PREPEND: begin
              if (stat_i.full) cmd_o.st = STS_FULL;
              else cmd_o.wr_head = 1'b1;
            end
            ACT_REMOVE: begin
              cmd_o.drop     = stat_i.hit;
              cmd_o.drop_val = 1'b1;
              cmd_o.found    = stat_i.hit;
            end
            ACT_REMOVE_AT: begin
              if (stat_i.pos_ok) cmd_o.drop = 1'b1;
              else cmd_o.st = STS_RANGE;
            end
            ACT_CLEAR: begin
              cmd_o.clear = 1'b1;
            end
            ACT_READ_AT: begin
              if (stat_i.pos_ok) cmd_o.rd_en = 1'b1;
              else cmd_o.st = STS_RANGE;
            end
            ACT_INCLUDES: begin
              cmd_o.found = stat_i.hit;
            end
            ACT_POP: begin
              if (stat_i.empty) begin
                cmd_o.st = STS_RANGE;
              end else begin
                cmd_o.rd_en  = 1'b1;
                cmd_o.rd_pop = 1'b1;
                cmd_o.pop    = 1'b1;
              end
            end
          endcase
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Output beat valid: set on execute, cleared when taken.
  always_comb begin
    m_valid_d = m_valid_q;
    if (cmd_o.exec) m_valid_d = 1'b1;
    else if (m_tready_i) m_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      m_valid_q <= m_valid_d;
    end
  end

endmodule

// File: rtl/bale_dp.sv
// Datapath of the bounded array list engine: request register, list cells and result register.
module bale_dp
  import bale_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  action_e           req_action_i,
  input  logic [31:0]       req_value_i,
  input  logic [POS_W-1:0]  req_pos_i,
  input  cmd_t              cmd_i,
  output stat_t             stat_o,
  output logic [39:0]       rsp_data_o
);

  action_e          act_q;
  item_t            val_q;
  logic [POS_W-1:0] pos_q;
  item_t            cell_q [CAPACITY];
  item_t            cell_d [CAPACITY];
  cnt_t             count_q, count_d;
  logic [CAPACITY-1:0] match;
  logic [CAPACITY-1:0] drop_sel;
  logic [31:0]      rd_q;
  logic             found_q;
  logic [4:0]       cnt_out_q;
  status_e          st_q;
  cnt_t             cnt_m1;
  idx_t             rd_idx;
  idx_t             tail_idx;
  item_t            rd_item;

  // Request register, loaded when a beat is accepted.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      act_q <= req_action_i;
      val_q <= to_item(req_value_i);
      pos_q <= req_pos_i;
    end
  end

  assign cnt_m1   = count_q - cnt_t'(1);
  assign rd_idx   = cmd_i.rd_pop ? cnt_m1[IDX_W-1:0] : IDX_W'(pos_q);
  assign tail_idx = count_q[IDX_W-1:0];
  assign rd_item  = cell_q[rd_idx];

  // Per-cell compare, shift select and next value.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    item_t nxt;

    assign match[i]    = (cell_q[i] == val_q) && (CNT_W'(i) < count_q);
    assign drop_sel[i] = cmd_i.drop_val ? (|match[i:0]) : (CMP_W'(i) >= CMP_W'(pos_q));

    always_comb begin
      nxt = cell_q[i];
      if (cmd_i.wr_head) begin
        if (i == 0) nxt = val_q;
        else nxt = cell_q[(i == 0) ? 0 : i - 1];
      end else if (cmd_i.wr_tail && (tail_idx == IDX_W'(i))) begin
        nxt = val_q;
      end else if (cmd_i.drop && drop_sel[i] && (i < CAPACITY - 1)) begin
        nxt = cell_q[(i < CAPACITY - 1) ? i + 1 : i];
      end
    end

    assign cell_d[i] = nxt;
  end

  always_ff @(posedge clk_i) begin
    cell_q <= cell_d;
  end

  // Count update.
  always_comb begin
    count_d = count_q;
    priority if (cmd_i.clear) count_d = '0;
    else if (cmd_i.wr_head || cmd_i.wr_tail) count_d = count_q + cnt_t'(1);
    else if (cmd_i.drop || cmd_i.pop) count_d = cnt_m1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) count_q <= '0;
    else count_q <= count_d;
  end

  // Result register, loaded on execute.
  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) begin
      rd_q      <= cmd_i.rd_en ? from_item(rd_item) : 32'd0;
      found_q   <= cmd_i.found;
      cnt_out_q <= from_cnt(count_d);
      st_q      <= cmd_i.st;
    end
  end

  assign stat_o.act    = act_q;
  assign stat_o.full   = (count_q == CAP_CNT);
  assign stat_o.empty  = (count_q == '0);
  assign stat_o.pos_ok = CMP_W'(pos_q) < CMP_W'(count_q);
  assign stat_o.hit    = |match;

  assign rsp_data_o = {st_q, cnt_out_q, found_q, rd_q};

endmodule

// File: rtl/bounded_array_list_engine_core.sv
// Top level of the bounded array list engine: controller, datapath and checks.
//
// Holds an ordered list of up to CAPACITY items packed from position 0 in a row
// of registered cells. Each request beat passes through a capture step, which
// registers the request, and an execute step, in which every cell compares and
// shifts in parallel and the result register is loaded; the next request is
// accepted while that result beat still waits. A result beat that is not taken
// holds the engine in its execute step until the output register frees. The
// cells need no clearing after reset, and clear only zeroes the count.
`include "bounded_array_list_engine_core_defines.svh"
module bounded_array_list_engine_core
  import bale_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // item_value[31:0], position[35:32], zero[39:36]
  input  logic [2:0]  s_tuser,   // action[2:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata    // read_value[31:0], found[32], item_count[37:33], status[39:38]
);

  cmd_t  cmd;
  stat_t stat;

  bale_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_tvalid),
    .s_tready_o (s_tready),
    .m_tvalid_o (m_tvalid),
    .m_tready_i (m_tready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  bale_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_action_i (action_e'(s_tuser)),
    .req_value_i  (s_tdata[31:0]),
    .req_pos_i    (s_tdata[35:32]),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .rsp_data_o   (m_tdata)
  );

  // An accepted beat is followed by an execute cycle, never by another accept.
  `BALE_ASSERT_NEXT(a_accept_then_busy, clk_i, rst_ni, s_tvalid && s_tready, !s_tready, "request accepted while executing")

  // The reported count never exceeds the list capacity.
  `BALE_ASSERT_IMPL(a_count_bound, clk_i, rst_ni, m_tvalid, 32'(m_tdata[37:33]) <= 32'(CAPACITY), "count beyond capacity")

  // A full status comes only with a full list.
  `BALE_ASSERT_IMPL(a_full_count, clk_i, rst_ni, m_tvalid && (m_tdata[39:38] == STS_FULL), 32'(m_tdata[37:33]) == 32'(CAPACITY), "full status with room left")

  // A rejected request reads nothing and finds nothing.
  `BALE_ASSERT_IMPL(a_error_quiet, clk_i, rst_ni, m_tvalid && (m_tdata[39:38] != STS_OK), (m_tdata[31:0] == 32'd0) && !m_tdata[32], "rejected request returned data")

endmodule
